FILE: rtl/core/x2d_pkg.sv
`timescale 1ns / 1ps

package x2d_pkg;

    localparam int unsigned ExtBias   = 16383;
    localparam int unsigned ExtExpMax = 32767;
    localparam int unsigned DblBias   = 1023;
    localparam int unsigned DblExpMax = 2047;
    localparam int unsigned SigWidth  = 64;
    localparam int unsigned ExpWidth  = 18;
    localparam int unsigned ShWidth   = 7;

    localparam logic [63:0] DblInfBits  = 64'h7FF0_0000_0000_0000;
    localparam logic [63:0] DblQnanBits = 64'h7FF8_0000_0000_0000;

    typedef enum logic [1:0] {
        CLASS_ZERO   = 2'd0,
        CLASS_FINITE = 2'd1,
        CLASS_INF    = 2'd2,
        CLASS_NAN    = 2'd3
    } value_class_t;

    // Leading zero count of a 64-bit word; zero input gives 63, guarded by the caller
    function automatic logic [5:0] lzc64(input logic [63:0] v);
        logic [5:0] cnt;
        cnt = 6'd63;
        for (int i = 0; i < 64; i++)
        begin
            if (v[i])
            begin
                cnt = 6'(63 - i);
            end
        end
        return cnt;
    endfunction

endpackage

FILE: rtl/core/extended_to_double_converter_unit.sv
`timescale 1ns / 1ps

// Converts an 80-bit extended-precision value (sign/exponent word plus a 64-bit
// significand with explicit integer bit) into an IEEE double bit pattern and a
// class code, rounding once to nearest-even, subnormal results included.
// Fully pipelined: one transaction is accepted every cycle while in_stall is
// low, and each result passes through the input register, leading zero count,
// normalize shift, subnormal alignment, and round and pack. The whole pipeline
// advances together; in_stall rises only when the output register holds a
// result that the receiver is stalling.
module extended_to_double_converter_unit
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [15:0]               sign_exponent,
    input  logic [63:0]               mantissa,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [63:0]               result_bits,
    output x2d_pkg::value_class_t     value_class
);
    import x2d_pkg::*;

    logic advance;

    // stage 1: input register
    logic        v1_reg;
    logic        sign1_reg;
    logic [14:0] exp1_reg;
    logic [63:0] man1_reg;

    // stage 2: leading zero count and special cases
    logic        v2_reg;
    logic        sign2_reg;
    logic        special2_reg;
    value_class_t spec_class2_reg;
    logic [63:0] spec_bits2_reg;
    logic [14:0] exp2_reg;
    logic [5:0]  lzc2_reg;
    logic [63:0] man2_reg;

    // stage 3: normalized significand and double exponent
    logic                        v3_reg;
    logic                        sign3_reg;
    logic                        special3_reg;
    value_class_t                spec_class3_reg;
    logic [63:0]                 spec_bits3_reg;
    logic signed [ExpWidth-1:0]  be3_reg;
    logic [63:0]                 norm3_reg;

    // stage 4: aligned significand with guard and sticky
    logic                        v4_reg;
    logic                        sign4_reg;
    logic                        special4_reg;
    value_class_t                spec_class4_reg;
    logic [63:0]                 spec_bits4_reg;
    logic                        is_norm4_reg;
    logic signed [ExpWidth-1:0]  be4_reg;
    logic [52:0]                 kept4_reg;
    logic                        guard4_reg;
    logic                        sticky4_reg;

    // stage 5: output register
    logic         v5_reg;
    logic [63:0]  bits5_reg;
    value_class_t class5_reg;

    logic                        special2_next;
    value_class_t                spec_class2_next;
    logic [63:0]                 spec_bits2_next;
    logic signed [ExpWidth-1:0]  be3_next;
    logic [63:0]                 norm3_next;
    logic [ShWidth-1:0]          sh4;
    logic [127:0]                wide4;
    logic                        is_norm4_next;
    logic [53:0]                 sig5;
    logic                        inc5;
    logic signed [ExpWidth-1:0]  exp5;
    logic [63:0]                 bits5_next;
    value_class_t                class5_next;

    assign advance  = !v5_reg || !out_stall;
    assign in_stall = !advance;

    always_comb
    begin
        special2_next    = 1'b0;
        spec_class2_next = CLASS_ZERO;
        spec_bits2_next  = 64'd0;
        if (exp1_reg == 15'(ExtExpMax))
        begin
            special2_next = 1'b1;
            if (man1_reg == 64'd0)
            begin
                spec_class2_next = CLASS_INF;
                spec_bits2_next  = DblInfBits;
            end
            else
            begin
                spec_class2_next = CLASS_NAN;
                spec_bits2_next  = DblQnanBits;
            end
        end
        else if (man1_reg == 64'd0)
        begin
            special2_next = 1'b1;
        end
    end

    always_comb
    begin
        norm3_next = man2_reg << lzc2_reg;
        be3_next   = $signed({3'b000, exp2_reg}) - $signed({12'd0, lzc2_reg})
                     - ExpWidth'(ExtBias - DblBias);
    end

    // Normal results keep 53 bits from the top; subnormals shift right by 1 - be, capped at 64
    always_comb
    begin
        is_norm4_next = be3_reg >= ExpWidth'(1);
        if (is_norm4_next)
        begin
            sh4 = '0;
        end
        else if (be3_reg < -ExpWidth'(63))
        begin
            sh4 = ShWidth'(SigWidth);
        end
        else
        begin
            sh4 = ShWidth'(ExpWidth'(1) - be3_reg);
        end
        wide4 = {norm3_reg, 64'd0} >> sh4;
    end

    always_comb
    begin
        inc5 = guard4_reg && (sticky4_reg || kept4_reg[0]);
        sig5 = {1'b0, kept4_reg} + {53'd0, inc5};
        exp5 = be4_reg + {{(ExpWidth-1){1'b0}}, sig5[53]};
        if (special4_reg)
        begin
            bits5_next  = spec_bits4_reg;
            class5_next = spec_class4_reg;
        end
        else if (is_norm4_reg)
        begin
            if (exp5 >= ExpWidth'(DblExpMax))
            begin
                bits5_next  = DblInfBits;
                class5_next = CLASS_INF;
            end
            else
            begin
                bits5_next  = {1'b0, exp5[10:0], sig5[51:0]};
                class5_next = CLASS_FINITE;
            end
        end
        else
        begin
            bits5_next  = {10'd0, sig5};
            class5_next = (sig5 == 54'd0) ? CLASS_ZERO : CLASS_FINITE;
        end
        bits5_next[63] = sign4_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            sign1_reg       <= sign_exponent[15];
            exp1_reg        <= sign_exponent[14:0];
            man1_reg        <= mantissa;

            sign2_reg       <= sign1_reg;
            special2_reg    <= special2_next;
            spec_class2_reg <= spec_class2_next;
            spec_bits2_reg  <= spec_bits2_next;
            exp2_reg        <= exp1_reg;
            lzc2_reg        <= lzc64(man1_reg);
            man2_reg        <= man1_reg;

            sign3_reg       <= sign2_reg;
            special3_reg    <= special2_reg;
            spec_class3_reg <= spec_class2_reg;
            spec_bits3_reg  <= spec_bits2_reg;
            be3_reg         <= be3_next;
            norm3_reg       <= norm3_next;

            sign4_reg       <= sign3_reg;
            special4_reg    <= special3_reg;
            spec_class4_reg <= spec_class3_reg;
            spec_bits4_reg  <= spec_bits3_reg;
            is_norm4_reg    <= is_norm4_next;
            be4_reg         <= be3_reg;
            kept4_reg       <= wide4[127:75];
            guard4_reg      <= wide4[74];
            sticky4_reg     <= |wide4[73:0];

            bits5_reg       <= bits5_next;
            class5_reg      <= class5_next;
        end
    end

    assign out_valid   = v5_reg;
    assign result_bits = bits5_reg;
    assign value_class = class5_reg;

endmodule
